>>> rtl/mcrn_pkg.sv
// ----------------------------------------------------------------------------
// mcrn_pkg: shared definitions for the matrix column and row norm block
// Widths, position flags and the saturating add used by the datapath.
// ----------------------------------------------------------------------------
package mcrn_pkg;

  localparam int MAX_ORDER = 64;
  localparam int ADDR_W    = $clog2(MAX_ORDER);
  localparam int ORD_W     = $clog2(MAX_ORDER + 1);
  localparam int ELEM_W    = 32;
  localparam int MAG_W     = 32;
  localparam int SUM_W     = 38;

  // where an element sits in the matrix
  typedef struct packed {
    logic first_row;
    logic last_row;
    logic last_col;
  } mcrn_pos_t;

  // two's complement magnitude; the most negative value gives 2^31 exactly
  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [ELEM_W-1:0] v);
    logic [MAG_W-1:0] raw;
    raw = MAG_W'(v);
    return v[ELEM_W-1] ? (~raw + MAG_W'(1)) : raw;
  endfunction

  // add, clamping at all ones
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [MAG_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W + 1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

>>> rtl/mcrn_if.sv
// ----------------------------------------------------------------------------
// mcrn_if: request channels of the matrix column and row norm block
// Element channel in, norm pair channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcrn_elem_if import mcrn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface mcrn_norm_if import mcrn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] column_norm;
  logic [SUM_W-1:0] row_norm;

  modport source (output valid, output column_norm, output row_norm, input ready);
  modport sink   (input valid, input column_norm, input row_norm, output ready);
endinterface

>>> rtl/mcrn_col_ram.sv
// ----------------------------------------------------------------------------
// mcrn_col_ram: column sum store
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module mcrn_col_ram import mcrn_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [SUM_W-1:0]  rd_data_r,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [SUM_W-1:0]  wr_data
);

  logic [SUM_W-1:0] mem [MAX_ORDER];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/mcrn_accum.sv
// ----------------------------------------------------------------------------
// mcrn_accum: sum update and maxima
// Forms the new column sum, keeps the running row sum and both maxima.
// ----------------------------------------------------------------------------
module mcrn_accum import mcrn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             step,
  input  mcrn_pos_t        pos,
  input  logic [MAG_W-1:0] mag,
  input  logic [SUM_W-1:0] col_old,
  output logic [SUM_W-1:0] col_sum,
  output logic [SUM_W-1:0] col_max_nxt,
  output logic [SUM_W-1:0] row_max_nxt
);

  logic [SUM_W-1:0] row_run_r, row_run_nxt;
  logic [SUM_W-1:0] col_max_r, row_max_r;
  logic [SUM_W-1:0] row_acc;

  // first row overwrites, later rows add
  assign col_sum = pos.first_row ? SUM_W'(mag) : sat_add(col_old, mag);
  assign row_acc = sat_add(row_run_r, mag);

  assign col_max_nxt = (pos.last_row && (col_sum > col_max_r)) ? col_sum : col_max_r;
  assign row_max_nxt = (pos.last_col && (row_acc > row_max_r)) ? row_acc : row_max_r;
  assign row_run_nxt = pos.last_col ? '0 : row_acc;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      row_run_r <= '0;
      col_max_r <= '0;
      row_max_r <= '0;
    end else if (step) begin
      if (pos.last_row && pos.last_col) begin
        row_run_r <= '0;
        col_max_r <= '0;
        row_max_r <= '0;
      end else begin
        row_run_r <= row_run_nxt;
        col_max_r <= col_max_nxt;
        row_max_r <= row_max_nxt;
      end
    end
  end

endmodule

>>> rtl/matrix_column_and_row_norm.sv
// ----------------------------------------------------------------------------
// matrix_column_and_row_norm: one-norm and infinity-norm of a square matrix
// Streams row-major Q15.16 elements and returns the largest column and row
// sums of absolute values once the last element is in.
// ----------------------------------------------------------------------------
// Usage: write the order n (1..64; 0 acts as 1, above 64 acts as 64) on
// cfg_wr_en/cfg_wr_data while idle; a write also abandons a matrix in
// progress. Then send n*n elements, row-major. The block takes one element
// per clock unless a final element waits for the result slot: the column
// sum store RAM is read (registered) on accept and written back as the
// element retires from stage 1, so no forwarding is needed. The norm pair
// request leaves via the result register once the last element retires
// and stays there until taken; only the last element of the next matrix
// waits on it. No clearing pass: row 0 overwrites every column sum first.
// ----------------------------------------------------------------------------
module matrix_column_and_row_norm import mcrn_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [ORD_W-1:0]   cfg_wr_data,
  mcrn_elem_if.sink          in_ch,
  mcrn_norm_if.source        out_ch
);

  // effective order, clamped on write
  logic [ORD_W-1:0]  order_r;
  logic [ORD_W-1:0]  order_nxt;

  // position of the next element
  logic [ADDR_W-1:0] col_pos_r, col_pos_nxt;
  logic [ADDR_W-1:0] row_pos_r, row_pos_nxt;

  // stage 1: element waiting for its column sum from the RAM
  logic              s1_valid_r, s1_valid_nxt;
  mcrn_pos_t         s1_pos_r;
  logic [MAG_W-1:0]  s1_mag_r;
  logic [ADDR_W-1:0] s1_col_r;

  // result register
  logic              out_valid_r;
  logic [SUM_W-1:0]  col_norm_r, row_norm_r;

  logic              in_fire, s1_done, s1_final;
  mcrn_pos_t         in_pos;
  logic [SUM_W-1:0]  ram_rd_data, col_sum, col_max_nxt, row_max_nxt;

  // ---- order register --------------------------------------------------------
  always_comb begin
    order_nxt = cfg_wr_data;
    if (cfg_wr_data == '0) begin
      order_nxt = ORD_W'(1);
    end else if (cfg_wr_data > ORD_W'(MAX_ORDER)) begin
      order_nxt = ORD_W'(MAX_ORDER);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORD_W'(1);
    end else if (cfg_wr_en) begin
      order_r <= order_nxt;
    end
  end

  // ---- handshake -------------------------------------------------------------
  // the final element of a matrix may only retire into an empty result slot or one taken in the same cycle
  assign s1_final = s1_pos_r.last_row && s1_pos_r.last_col;
  assign s1_done  = s1_valid_r && (!s1_final || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_done;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // ---- position counters -----------------------------------------------------
  assign in_pos.first_row = (row_pos_r == '0);
  assign in_pos.last_row  = ({1'b0, row_pos_r} == (order_r - ORD_W'(1)));
  assign in_pos.last_col  = ({1'b0, col_pos_r} == (order_r - ORD_W'(1)));

  always_comb begin
    col_pos_nxt = col_pos_r + ADDR_W'(1);
    row_pos_nxt = row_pos_r;
    if (in_pos.last_col) begin
      col_pos_nxt = '0;
      row_pos_nxt = in_pos.last_row ? '0 : row_pos_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (in_fire) begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
    end
  end

  // ---- stage 1 ---------------------------------------------------------------
  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_done ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos_r <= in_pos;
      s1_mag_r <= abs_mag(in_ch.element_value);
      s1_col_r <= col_pos_r;
    end
  end

  // ---- column sum store: read on accept, write back on retire ---------------
  mcrn_col_ram u_col_ram (
    .clk       (clk),
    .rd_en     (in_fire),
    .rd_addr   (col_pos_r),
    .rd_data_r (ram_rd_data),
    .wr_en     (s1_done),
    .wr_addr   (s1_col_r),
    .wr_data   (col_sum)
  );

  mcrn_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .clear       (cfg_wr_en),
    .step        (s1_done),
    .pos         (s1_pos_r),
    .mag         (s1_mag_r),
    .col_old     (ram_rd_data),
    .col_sum     (col_sum),
    .col_max_nxt (col_max_nxt),
    .row_max_nxt (row_max_nxt)
  );

  // ---- result register -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done && s1_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1_final) begin
      col_norm_r <= col_max_nxt;
      row_norm_r <= row_max_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.column_norm = col_norm_r;
  assign out_ch.row_norm    = row_norm_r;

  // ---- assertions ------------------------------------------------------------
  // stage 1 only holds a final element that waits for the result slot
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_done) |-> (out_valid_r && !out_ch.ready && s1_final))
    else $error("stage 1 stalled without a blocked result");

  // positions stay inside the matrix
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_pos_r} < order_r) && ({1'b0, row_pos_r} < order_r))
    else $error("element position beyond matrix order");

  // a result appears only after the final element retired
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_done && s1_final))
    else $error("result raised without a final element");

  // a held result is not overwritten
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> ($stable(col_norm_r) && $stable(row_norm_r)))
    else $error("pending result overwritten");

endmodule

>>> bench/mcrn_norm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcrn_norm_checker: prediction and checking of norm pair requests
// Follows order register writes and accepted element requests, works out the
// one-norm and infinity-norm of every complete matrix, and compares each norm
// pair request leaving the block with the oldest prediction.
// ----------------------------------------------------------------------------
module mcrn_norm_checker import mcrn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [ORD_W-1:0] cfg_wr_data,
  mcrn_elem_if             elem_mon,
  mcrn_norm_if             norm_mon,
  output int unsigned      norms_awaited,
  output int unsigned      fault_total
);

  localparam int               REPORT_MAX = 10;
  localparam logic [SUM_W-1:0] SUM_CEIL   = {SUM_W{1'b1}};

  typedef struct packed {
    logic [SUM_W-1:0] column_norm;
    logic [SUM_W-1:0] row_norm;
  } norm_pair_t;

  norm_pair_t       norms_due[$];
  logic [SUM_W-1:0] column_tally [MAX_ORDER];
  logic [SUM_W-1:0] row_tally;
  logic [SUM_W-1:0] row_peak;
  logic [SUM_W-1:0] column_peak;
  logic [ORD_W-1:0] order_q;
  int unsigned      row_at;
  int unsigned      col_at;
  int unsigned      faults = 0;

  // order register as the datapath uses it: 0 acts as 1, clamped at MAX_ORDER
  function automatic int unsigned order_in_use(input logic [ORD_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > ORD_W'(MAX_ORDER)) return MAX_ORDER;
    return int'(raw);
  endfunction

  function automatic logic [SUM_W-1:0] tally_add(input logic [SUM_W-1:0] acc,
                                                 input logic [32:0]      mag);
    logic [SUM_W:0] wide;
    wide = (SUM_W + 1)'(acc) + (SUM_W + 1)'(mag);
    return (wide > (SUM_W + 1)'(SUM_CEIL)) ? SUM_CEIL : wide[SUM_W-1:0];
  endfunction

  function automatic void restart_matrix();
    row_tally   = '0;
    row_peak    = '0;
    column_peak = '0;
    row_at      = 0;
    col_at      = 0;
  endfunction

  task automatic absorb_element(input logic signed [ELEM_W-1:0] elem);
    int unsigned        n;
    int unsigned        c;
    int unsigned        r;
    logic signed [32:0] sx;
    logic [32:0]        mag;
    logic [SUM_W-1:0]   col_new;
    norm_pair_t         due;
    n   = order_in_use(order_q);
    sx  = elem;
    // one extra bit keeps the most negative value's magnitude exact
    mag = (sx < 0) ? -sx : sx;
    c   = (col_at >= n) ? n - 1 : col_at;
    r   = (row_at >= n) ? n - 1 : row_at;
    // the first row overwrites, later rows accumulate
    col_new         = (r == 0) ? SUM_W'(mag) : tally_add(column_tally[c], mag);
    column_tally[c] = col_new;
    row_tally       = tally_add(row_tally, mag);
    if (r == n - 1 && col_new > column_peak) column_peak = col_new;
    if (c == n - 1) begin
      if (row_tally > row_peak) row_peak = row_tally;
      row_tally = '0;
      col_at    = 0;
      if (r == n - 1) begin
        due.column_norm = column_peak;
        due.row_norm    = row_peak;
        norms_due.push_back(due);
        restart_matrix();
      end else begin
        row_at = r + 1;
      end
    end else begin
      col_at = c + 1;
      row_at = r;
    end
  endtask

  always @(posedge clk) begin
    norm_pair_t want;
    if (!rst_n) begin
      norms_due.delete();
      order_q = ORD_W'(1);
      restart_matrix();
    end else begin
      // a norm pair passes stage 1 and the result register after its last element,
      // so it never leaves with it; retire first and predict afterwards
      if (norm_mon.valid && norm_mon.ready) begin
        if (norms_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX)
            $display("%0t: norm request with none predicted: col=%0h row=%0h",
                     $realtime, norm_mon.column_norm, norm_mon.row_norm);
        end else begin
          want = norms_due.pop_front();
          if (norm_mon.column_norm != want.column_norm ||
              norm_mon.row_norm != want.row_norm) begin
            faults++;
            if (faults <= REPORT_MAX)
              $display("%0t: norm mismatch: expected col=%0h row=%0h, got col=%0h row=%0h",
                       $realtime, want.column_norm, want.row_norm,
                       norm_mon.column_norm, norm_mon.row_norm);
          end
        end
      end
      // a write abandons any matrix in progress
      if (cfg_wr_en) begin
        order_q = cfg_wr_data;
        restart_matrix();
      end
      if (elem_mon.valid && elem_mon.ready) absorb_element(elem_mon.element_value);
    end
    norms_awaited <= norms_due.size();
    fault_total   <= faults;
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the matrix column and row norm block
// Streams directed and random matrices of many orders, with random gaps on
// the element side and random stalls on the norm side; the checker beside the
// block predicts every norm pair and counts faults.
// ----------------------------------------------------------------------------
module tb_top;
  import mcrn_pkg::*;

  localparam int unsigned RUN_LIMIT    = 600_000; // cycles before giving up
  localparam int unsigned RAND_ITEMS   = 480;     // elements in the random part
  localparam int unsigned MIN_MATRICES = 12;      // complete random matrices wanted
  localparam int unsigned SETTLE       = 4;       // covers the column store write-back

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [ORD_W-1:0] cfg_wr_data;
  int unsigned      norms_awaited;
  int unsigned      fault_total;

  // gap and stall chances in percent, changed per phase
  int unsigned      send_gap_pct = 0;
  int unsigned      take_gap_pct = 0;
  int unsigned      take_hold    = 0;

  mcrn_elem_if elem_bus ();
  mcrn_norm_if norm_bus ();

  matrix_column_and_row_norm i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (elem_bus),
    .out_ch      (norm_bus)
  );

  mcrn_norm_checker i_norm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .elem_mon      (elem_bus),
    .norm_mon      (norm_bus),
    .norms_awaited (norms_awaited),
    .fault_total   (fault_total)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // norm side back-pressure: random bursts with ready low
  always @(posedge clk) begin
    if (take_hold != 0) begin
      take_hold      <= take_hold - 1;
      norm_bus.ready <= 1'b0;
    end else if (take_gap_pct != 0 && $urandom_range(99) < take_gap_pct) begin
      take_hold      <= $urandom_range(16, 0);
      norm_bus.ready <= 1'b0;
    end else begin
      norm_bus.ready <= 1'b1;
    end
  end

  // watchdog
  initial begin
    int unsigned cycle_count;
    for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Element values: the two extremes, zero, minus one, small Q15.16 values of
  // either sign, and raw random words for the rest.
  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(9))
      0:       return ELEM_W'(32'h8000_0000);
      1:       return ELEM_W'(32'h7FFF_FFFF);
      2:       return '0;
      3:       return ELEM_W'(32'hFFFF_FFFF);
      4:       return ELEM_W'($urandom_range(32'h0004_0000));
      5:       return ELEM_W'(0 - $urandom_range(32'h0004_0000));
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // One element request. Valid stays high between back-to-back requests and
  // drops only for a gap, so it never gets two updates in one step.
  task automatic send_element(input logic signed [ELEM_W-1:0] elem);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      elem_bus.valid <= 1'b0;
      repeat ($urandom_range(17, 1)) @(posedge clk);
    end
    elem_bus.valid         <= 1'b1;
    elem_bus.element_value <= elem;
    do @(posedge clk); while (!elem_bus.ready);
  endtask

  // Order writes happen only with the block idle: every predicted norm pair
  // taken, then a settling wait for a pending column store write-back. The first
  // edge of the wait also lets the checker's count catch up.
  task automatic write_order(input logic [ORD_W-1:0] order_cfg);
    elem_bus.valid <= 1'b0;
    do @(posedge clk); while (norms_awaited != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order_cfg;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic signed [ELEM_W-1:0] lone_vals  [5];
    logic signed [ELEM_W-1:0] three_vals [9];
    logic signed [ELEM_W-1:0] pair_vals  [4];
    logic [ORD_W-1:0]         order_cfg;
    int unsigned              n_eff;
    int unsigned              n_rand;
    int unsigned              n_done;
    int unsigned              phase;
    int unsigned              mats;
    int unsigned              m;
    int unsigned              count;
    int unsigned              k;
    bit                       big;

    lone_vals  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0001_0000};
    three_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                   32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFE_8000,
                   32'h0003_4000, 32'h8000_0000, 32'h7FFF_FFFF};
    pair_vals  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0005, 32'hFFFF_FFF9};

    elem_bus.valid         = 1'b0;
    elem_bus.element_value = '0;
    norm_bus.ready         = 1'b0;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = '0;
    rst_n                  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    send_gap_pct = 20;
    take_gap_pct = 20;

    // order after reset is 1: each element is a whole matrix, both norms |a|
    foreach (lone_vals[i]) send_element(lone_vals[i]);

    // order 0 behaves as order 1; most negative element gives 2^31
    write_order(ORD_W'(0));
    send_element(ELEM_W'(32'h8000_0000));

    // order 3 with extremes in the first and last rows
    write_order(ORD_W'(3));
    foreach (three_vals[i]) send_element(three_vals[i]);

    // a write part-way through a matrix abandons it; then a clean order 2
    write_order(ORD_W'(2));
    for (k = 0; k < 3; k++) send_element(pair_vals[k]);
    write_order(ORD_W'(2));
    foreach (pair_vals[i]) send_element(pair_vals[i]);

    // ---- random part ----
    // Mostly small complete matrices with random content; a few rows at the
    // largest order and at an order that saturates to it, left unfinished;
    // now and then a small matrix cut short by the next write.
    n_rand  = 0;
    n_done  = 0;
    phase   = 0;
    while (n_rand < RAND_ITEMS || n_done < MIN_MATRICES) begin
      phase++;
      big = 1'b0;
      if (phase == 2) begin
        order_cfg = ORD_W'(MAX_ORDER);
        big       = 1'b1;
      end else if (phase == 5) begin
        order_cfg = '1;
        big       = 1'b1;
      end else begin
        case ($urandom_range(9))
          0:       order_cfg = '0;
          1, 2, 3: order_cfg = ORD_W'($urandom_range(2, 1));
          4, 5, 6: order_cfg = ORD_W'($urandom_range(5, 3));
          7, 8:    order_cfg = ORD_W'($urandom_range(8, 6));
          default: order_cfg = ORD_W'($urandom_range(12, 9));
        endcase
      end
      n_eff = (order_cfg == '0) ? 1 :
              (order_cfg > ORD_W'(MAX_ORDER)) ? MAX_ORDER : int'(order_cfg);

      write_order(order_cfg);

      // some phases run flat out, others with light or heavy idling
      if (big) begin
        send_gap_pct = 3;
        take_gap_pct = 3;
        mats         = 1;
      end else begin
        case ($urandom_range(3))
          0:       send_gap_pct = 0;
          1:       send_gap_pct = 5;
          2:       send_gap_pct = 20;
          default: send_gap_pct = 50;
        endcase
        case ($urandom_range(3))
          0:       take_gap_pct = 0;
          1:       take_gap_pct = 10;
          2:       take_gap_pct = 30;
          default: take_gap_pct = 60;
        endcase
        mats = $urandom_range(4, 1);
      end

      for (m = 0; m < mats; m++) begin
        count = n_eff * n_eff;
        if (big) begin
          // two to three rows at the largest order, abandoned by the next write
          count = $urandom_range(3 * n_eff, 2 * n_eff);
        end else if (m == mats - 1 && count > 1 && $urandom_range(7) == 0) begin
          // cut the last matrix of the phase short now and then
          count = $urandom_range(count - 1, 1);
        end else begin
          n_done++;
        end
        for (k = 0; k < count; k++) send_element(pick_element());
        n_rand += count;
      end
    end

    // ---- closing stretch: no idling on either side ----
    send_gap_pct = 0;
    take_gap_pct = 0;
    write_order(ORD_W'(4));
    for (k = 0; k < 48; k++) send_element(pick_element());

    elem_bus.valid <= 1'b0;
    do @(posedge clk); while (norms_awaited != 0);
    repeat (10) @(posedge clk);

    if (fault_total == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
